FILE: rtl/drrip_pkg.sv
package drrip_pkg;

   // fixed field widths of the request and response beats
   localparam int IN_SET_W = 11;
   localparam int IN_WAY_W = 4;
   localparam int MASK_W   = 16;
   localparam int ADDR_W   = 64;

   // re-reference prediction values
   localparam int RRPV_W = 2;
   localparam logic [RRPV_W-1:0] RRPV_MAX  = 2'd3;
   localparam logic [RRPV_W-1:0] RRPV_LONG = 2'd2;
   localparam logic [RRPV_W-1:0] RRPV_NEAR = 2'd0;

   // stride detector score, saturating
   localparam int SCORE_W = 3;
   localparam logic signed [SCORE_W-1:0] SCORE_MAX    = 3'sd3;
   localparam logic signed [SCORE_W-1:0] SCORE_MIN    = -3'sd2;
   localparam logic signed [SCORE_W-1:0] SCORE_ONE    = 3'sd1;
   localparam logic signed [SCORE_W-1:0] SCORE_STREAM = 3'sd2;

   // bimodal insertion draw
   localparam int LFSR_W = 16;
   localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
   localparam int DRAW_BITS = 5;

   localparam logic KIND_VICTIM = 1'b0;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_EXEC
   } state_type;

   typedef enum logic [1:0] {
      ROLE_SRRIP,
      ROLE_BRRIP,
      ROLE_LIP,
      ROLE_FOLLOW
   } role_type;

   typedef struct packed {
      logic rd;
      logic wr;
      logic clr;
   } mem_op_type;

endpackage

FILE: rtl/drrip_req_if.sv
interface drrip_req_if import drrip_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                kind;
   logic [IN_SET_W-1:0] set_index;
   logic [IN_WAY_W-1:0] way_index;
   logic [MASK_W-1:0]   valid_mask;
   logic [ADDR_W-1:0]   phys_addr;
   logic                is_hit;

   modport source (
      output valid, kind, set_index, way_index, valid_mask, phys_addr, is_hit,
      input  ready
   );
   modport sink (
      input  valid, kind, set_index, way_index, valid_mask, phys_addr, is_hit,
      output ready
   );
endinterface

FILE: rtl/drrip_rsp_if.sv
interface drrip_rsp_if import drrip_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [IN_WAY_W-1:0] victim_way;

   modport source (
      output valid, victim_way,
      input  ready
   );
   modport sink (
      input  valid, victim_way,
      output ready
   );
endinterface

FILE: rtl/drrip_lip_stream_replacement.sv
// Flow: an accepted beat is looked up in the following cycle and retired in ST_EXEC,
//    a victim beat only into a free response slot; its victim way is registered on rsp.
// Pacing: the single RRPV/stride memory port alternates a row read and a row write,
//    so a new beat is accepted only once the last one retires; a held response delays that.
// Reset: a clearing pass walks all NUM_SETS sets, writing RRPV 3 and empty stride
//    history into each; req.ready stays low until it finishes.
module drrip_lip_stream_replacement import drrip_pkg::*; #(
   parameter int NUM_SETS         = 2048,
   parameter int NUM_WAYS         = 16,
   parameter int LEADER_COUNT     = 64,
   parameter int DUEL_WIDTH       = 10,
   parameter int LINE_OFFSET_BITS = 6
) (
   input  logic        clock,
   input  logic        reset,
   drrip_req_if.sink   req,
   drrip_rsp_if.source rsp
);

   localparam int SET_BITS  = $clog2(NUM_SETS);
   localparam int WAY_BITS  = $clog2(NUM_WAYS);
   localparam int BLK_W     = ADDR_W - LINE_OFFSET_BITS;
   localparam int RW        = (SET_BITS > IN_SET_W) ? SET_BITS : IN_SET_W;
   localparam int WR_W      = IN_WAY_W + 2;
   localparam int WAY_STEPS = (2 ** IN_WAY_W) / NUM_WAYS;

   // set_index / NUM_SETS by reciprocal multiply, exact for 11-bit indexes
   localparam int    QK   = IN_SET_W + SET_BITS;
   localparam longint QM  = ((longint'(1) << QK) + NUM_SETS - 1) / NUM_SETS;
   localparam int    QM_W = IN_SET_W + 2;
   localparam int    QP_W = IN_SET_W + QM_W;
   localparam logic [QP_W-1:0] QM_C = QP_W'(QM);

   localparam logic [31:0] SRRIP_END = 32'(LEADER_COUNT / 3);
   localparam logic [31:0] BRRIP_END = 32'(2 * LEADER_COUNT / 3);
   localparam logic [31:0] LIP_END   = 32'(LEADER_COUNT);

   localparam logic [DUEL_WIDTH-1:0] DUEL_MID = DUEL_WIDTH'(1) << (DUEL_WIDTH - 1);
   localparam logic [DUEL_WIDTH-1:0] DUEL_MAX = '1;
   localparam logic [SET_BITS-1:0]   LAST_SET = SET_BITS'(NUM_SETS - 1);

   state_type state_ff, state_in;

   logic [SET_BITS-1:0] clr_cnt_ff, clr_cnt_in;

   // beat held from accept
   logic                kind_ff;
   logic [IN_SET_W-1:0] set_ff;
   logic [IN_SET_W-1:0] q_ff;
   logic [WAY_BITS-1:0] way_ff;
   logic [MASK_W-1:0]   mask_ff;
   logic [BLK_W-1:0]    blk_ff;
   logic [BLK_W:0]      blk_plus_ff;
   logic [BLK_W:0]      blk_minus_ff;
   logic                hit_ff;

   logic [QP_W-1:0]     prod;
   logic [IN_SET_W-1:0] q_in;
   logic [WR_W-1:0]     way_tmp;
   logic [WAY_BITS-1:0] way_red;
   logic [BLK_W-1:0]    blk_in;

   logic [RW-1:0]       r_full;
   logic [SET_BITS-1:0] set_idx_lk;
   logic [SET_BITS-1:0] set_idx_ff;
   logic [31:0]         set_wide;
   role_type            role_lk, role_ff;

   logic [SET_BITS-1:0] mem_addr;
   logic                accept;
   logic                exec_fire;
   logic                kind_update;
   logic                op_rd, op_wr, op_clr;
   mem_op_type          rrpv_op, stride_op;

   logic                streaming;
   logic [IN_WAY_W-1:0] victim_way;
   logic [RRPV_W-1:0]   depth;
   logic                brrip_pick;
   logic                uses_draw;
   logic                duel_moves;
   logic                draw;
   logic [LFSR_W-1:0]   lfsr_step;

   logic [LFSR_W-1:0]     lfsr_ff, lfsr_in;
   logic [DUEL_WIDTH-1:0] duel_ff, duel_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [IN_WAY_W-1:0]   victim_ff;

   assign accept      = req.valid && req.ready;
   assign kind_update = (kind_ff != KIND_VICTIM);

   // ---------------- accept-side prep ----------------
   always_comb begin
      prod    = QP_W'(req.set_index) * QM_C;
      q_in    = IN_SET_W'(prod >> QK);
      way_tmp = WR_W'(req.way_index);
      for (int i = 0; i < WAY_STEPS; i++) begin
         if (way_tmp >= WR_W'(NUM_WAYS)) begin
            way_tmp = way_tmp - WR_W'(NUM_WAYS);
         end
      end
      way_red = way_tmp[WAY_BITS-1:0];
      blk_in  = req.phys_addr[ADDR_W-1:LINE_OFFSET_BITS];
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff      <= req.kind;
         set_ff       <= req.set_index;
         q_ff         <= q_in;
         way_ff       <= way_red;
         mask_ff      <= req.valid_mask;
         blk_ff       <= blk_in;
         blk_plus_ff  <= {1'b0, blk_in} + 1'b1;
         blk_minus_ff <= {1'b0, blk_in} - 1'b1;
         hit_ff       <= req.is_hit;
      end
   end

   // ---------------- lookup: set remainder and role ----------------
   always_comb begin
      r_full     = RW'(set_ff) - RW'(q_ff * NUM_SETS);
      set_idx_lk = r_full[SET_BITS-1:0];
      set_wide   = 32'(set_idx_lk);
      if (set_wide < SRRIP_END) begin
         role_lk = ROLE_SRRIP;
      end else if (set_wide < BRRIP_END) begin
         role_lk = ROLE_BRRIP;
      end else if (set_wide < LIP_END) begin
         role_lk = ROLE_LIP;
      end else begin
         role_lk = ROLE_FOLLOW;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_LOOKUP) begin
         set_idx_ff <= set_idx_lk;
         role_ff    <= role_lk;
      end
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            state_in = (clr_cnt_ff == LAST_SET) ? ST_IDLE : ST_CLEAR;
         end
         ST_IDLE: begin
            state_in = req.valid ? ST_LOOKUP : ST_IDLE;
         end
         ST_LOOKUP: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (!exec_fire) begin
               state_in = ST_EXEC;
            end else if (req.valid) begin
               state_in = ST_LOOKUP;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      req.ready = 1'b0;
      exec_fire = 1'b0;
      op_rd     = 1'b0;
      op_wr     = 1'b0;
      op_clr    = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            op_wr  = 1'b1;
            op_clr = 1'b1;
         end
         ST_IDLE: begin
            req.ready = 1'b1;
         end
         ST_LOOKUP: begin
            op_rd = 1'b1;
         end
         ST_EXEC: begin
            // a victim beat retires only into a free response slot
            exec_fire = kind_update || !rsp_valid_ff || rsp.ready;
            req.ready = exec_fire;
            op_wr     = exec_fire;
         end
         default: ;
      endcase
   end

   assign clr_cnt_in = (state_ff == ST_CLEAR) ? clr_cnt_ff + 1'b1 : clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_comb begin
      case (state_ff)
         ST_CLEAR:  mem_addr = clr_cnt_ff;
         ST_LOOKUP: mem_addr = set_idx_lk;
         default:   mem_addr = set_idx_ff;
      endcase
   end

   assign rrpv_op   = '{rd: op_rd, wr: op_wr, clr: op_clr};
   assign stride_op = '{rd: op_rd, wr: op_wr && (op_clr || kind_update), clr: op_clr};

   // ---------------- state memories ----------------
   drrip_stride_unit #(
      .NUM_SETS (NUM_SETS),
      .BLK_W    (BLK_W)
   ) u_stride (
      .clock     (clock),
      .op        (stride_op),
      .addr      (mem_addr),
      .blk       (blk_ff),
      .blk_plus  (blk_plus_ff),
      .blk_minus (blk_minus_ff),
      .streaming (streaming)
   );

   drrip_rrpv_unit #(
      .NUM_SETS (NUM_SETS),
      .NUM_WAYS (NUM_WAYS)
   ) u_rrpv (
      .clock      (clock),
      .op         (rrpv_op),
      .addr       (mem_addr),
      .is_victim  (!kind_update),
      .valid_mask (mask_ff),
      .way        (way_ff),
      .depth      (depth),
      .victim_way (victim_way)
   );

   // ---------------- insertion policy ----------------
   always_comb begin
      lfsr_step  = {lfsr_ff[0] ^ lfsr_ff[2] ^ lfsr_ff[3] ^ lfsr_ff[5],
                    lfsr_ff[LFSR_W-1:1]};
      draw       = (lfsr_step[DRAW_BITS-1:0] == '0);
      brrip_pick = (role_ff == ROLE_BRRIP)
                || ((role_ff == ROLE_FOLLOW) && !duel_ff[DUEL_WIDTH-1]);
      uses_draw  = kind_update && !hit_ff && !streaming && brrip_pick;
      duel_moves = kind_update && (hit_ff || !streaming);

      if (hit_ff) begin
         depth = RRPV_NEAR;
      end else if (streaming) begin
         depth = RRPV_MAX;
      end else if (brrip_pick) begin
         depth = draw ? RRPV_NEAR : RRPV_LONG;
      end else if (role_ff == ROLE_LIP) begin
         depth = RRPV_MAX;
      end else begin
         depth = RRPV_LONG;
      end
   end

   always_comb begin
      lfsr_in = lfsr_ff;
      duel_in = duel_ff;
      if (exec_fire && uses_draw) begin
         lfsr_in = lfsr_step;
      end
      if (exec_fire && duel_moves) begin
         if ((role_ff == ROLE_SRRIP) && (duel_ff != DUEL_MAX)) begin
            duel_in = duel_ff + 1'b1;
         end else if ((role_ff == ROLE_BRRIP) && (duel_ff != '0)) begin
            duel_in = duel_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff <= LFSR_SEED;
         duel_ff <= DUEL_MID;
      end else begin
         lfsr_ff <= lfsr_in;
         duel_ff <= duel_in;
      end
   end

   // ---------------- response register ----------------
   always_comb begin
      if (exec_fire && !kind_update) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_fire && !kind_update) begin
         victim_ff <= victim_way;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.victim_way = victim_ff;

   // ---------------- assertions ----------------
   a_lfsr_live: assert property (@(posedge clock) disable iff (reset)
      lfsr_ff != '0)
      else $error("draw LFSR reached the all-zero lockup state");

   a_one_port: assert property (@(posedge clock) disable iff (reset)
      !(rrpv_op.rd && rrpv_op.wr))
      else $error("RRPV memory read and written in the same cycle");

   a_accept_lookup: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> state_ff == ST_LOOKUP)
      else $error("accepted beat did not move on to the row lookup");

   a_no_clobber: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |=> rsp_valid_ff && $stable(victim_ff))
      else $error("pending victim beat overwritten before it was taken");

endmodule

FILE: rtl/drrip_stride_unit.sv
module drrip_stride_unit import drrip_pkg::*; #(
   parameter int NUM_SETS = 2048,
   parameter int BLK_W    = 58
) (
   input  logic                        clock,
   input  mem_op_type                  op,
   input  logic [$clog2(NUM_SETS)-1:0] addr,
   input  logic [BLK_W-1:0]            blk,
   input  logic [BLK_W:0]              blk_plus,
   input  logic [BLK_W:0]              blk_minus,
   output logic                        streaming
);

   localparam int ROW_W = BLK_W + SCORE_W;

   // row: last block address seen, stride score
   logic [ROW_W-1:0] mem [NUM_SETS];
   logic [ROW_W-1:0] rdata_ff;
   logic [ROW_W-1:0] wdata;

   logic [BLK_W-1:0]          last;
   logic signed [SCORE_W-1:0] score;
   logic signed [SCORE_W-1:0] score_upd;
   logic signed [SCORE_W-1:0] score_new;
   logic                      have_last;
   logic                      near;

   always_ff @(posedge clock) begin
      if (op.wr) begin
         mem[addr] <= op.clr ? '0 : wdata;
      end
      if (op.rd) begin
         rdata_ff <= mem[addr];
      end
   end

   assign last      = rdata_ff[ROW_W-1:SCORE_W];
   assign score     = rdata_ff[SCORE_W-1:0];
   assign have_last = |last;
   // delta of +1 or -1 blocks; one extra bit keeps the wrap cases apart
   assign near      = ({1'b0, last} == blk_minus) || ({1'b0, last} == blk_plus);

   always_comb begin
      if (near) begin
         score_upd = (score < SCORE_MAX) ? score + SCORE_ONE : SCORE_MAX;
      end else begin
         score_upd = (score > SCORE_MIN) ? score - SCORE_ONE : SCORE_MIN;
      end
      score_new = have_last ? score_upd : score;
   end

   // the stream mark always equals score >= 2, so it is not stored
   assign streaming = (score_new >= SCORE_STREAM);
   assign wdata     = {blk, score_new};

endmodule

FILE: rtl/drrip_rrpv_unit.sv
module drrip_rrpv_unit import drrip_pkg::*; #(
   parameter int NUM_SETS = 2048,
   parameter int NUM_WAYS = 16
) (
   input  logic                        clock,
   input  mem_op_type                  op,
   input  logic [$clog2(NUM_SETS)-1:0] addr,
   input  logic                        is_victim,
   input  logic [MASK_W-1:0]           valid_mask,
   input  logic [$clog2(NUM_WAYS)-1:0] way,
   input  logic [RRPV_W-1:0]           depth,
   output logic [IN_WAY_W-1:0]         victim_way
);

   localparam int WAY_BITS = $clog2(NUM_WAYS);
   localparam int ROW_W    = NUM_WAYS * RRPV_W;

   logic [ROW_W-1:0] mem [NUM_SETS];
   logic [ROW_W-1:0] rdata_ff;
   logic [ROW_W-1:0] aged_row;
   logic [ROW_W-1:0] fill_row;
   logic [ROW_W-1:0] wdata;

   logic [NUM_WAYS-1:0] mask_ext;
   logic [NUM_WAYS-1:0] hi;
   logic [NUM_WAYS-1:0] lo;
   logic [RRPV_W-1:0]   top;
   logic [RRPV_W-1:0]   add;
   logic                any_free;
   logic [WAY_BITS-1:0] free_way;
   logic [WAY_BITS-1:0] old_way;

   always_ff @(posedge clock) begin
      if (op.wr) begin
         mem[addr] <= wdata;
      end
      if (op.rd) begin
         rdata_ff <= mem[addr];
      end
   end

   // ways past the mask count as invalid
   if (NUM_WAYS <= MASK_W) begin : g_mask_cut
      assign mask_ext = valid_mask[NUM_WAYS-1:0];
   end else begin : g_mask_pad
      assign mask_ext = {{(NUM_WAYS - MASK_W){1'b0}}, valid_mask};
   end

   always_comb begin
      for (int i = 0; i < NUM_WAYS; i++) begin
         hi[i] = rdata_ff[i*RRPV_W + 1];
         lo[i] = rdata_ff[i*RRPV_W];
      end
      // max over the row without a compare chain
      top[1] = |hi;
      top[0] = |(lo & (top[1] ? hi : ~hi));
      add    = RRPV_MAX - top;
      for (int i = 0; i < NUM_WAYS; i++) begin
         aged_row[i*RRPV_W +: RRPV_W] = rdata_ff[i*RRPV_W +: RRPV_W] + add;
         fill_row[i*RRPV_W +: RRPV_W] = (WAY_BITS'(i) == way) ? depth
                                        : rdata_ff[i*RRPV_W +: RRPV_W];
      end
   end

   always_comb begin
      any_free = ~&mask_ext;
      free_way = '0;
      old_way  = '0;
      for (int i = NUM_WAYS - 1; i >= 0; i--) begin
         if (!mask_ext[i]) begin
            free_way = WAY_BITS'(i);
         end
         if (aged_row[i*RRPV_W +: RRPV_W] == RRPV_MAX) begin
            old_way = WAY_BITS'(i);
         end
      end
   end

   assign victim_way = any_free ? IN_WAY_W'(free_way) : IN_WAY_W'(old_way);

   always_comb begin
      if (op.clr) begin
         wdata = {NUM_WAYS{RRPV_MAX}};
      end else if (is_victim) begin
         wdata = any_free ? rdata_ff : aged_row;
      end else begin
         wdata = fill_row;
      end
   end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;
   import drrip_pkg::*;

   localparam int NUM_SETS   = 2048;
   localparam int NUM_WAYS   = 16;
   localparam int LEADERS    = 64;
   localparam int DUEL_W     = 10;
   localparam int LINE_BITS  = 6;
   localparam logic [DUEL_W-1:0] DUEL_MAX = '1;
   localparam logic [DUEL_W-1:0] DUEL_MID = DUEL_W'(1) << (DUEL_W - 1);
   localparam logic KIND_UPDATE = ~KIND_VICTIM;

   localparam int RANDOM_BEATS = 1830;
   localparam int HOLD_AT      = 150;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 20;

   typedef struct {
      logic                kind;
      logic [IN_SET_W-1:0] set_index;
      logic [IN_WAY_W-1:0] way_index;
      logic [MASK_W-1:0]   valid_mask;
      logic [ADDR_W-1:0]   phys_addr;
      logic                is_hit;
   } access_type;

   logic clock;
   logic reset;

   drrip_req_if req_if ();
   drrip_rsp_if rsp_if ();

   drrip_lip_stream_replacement uut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   // replacement state mirror
   logic [RRPV_W-1:0]        rrpv_tbl   [NUM_SETS][NUM_WAYS];
   logic [DUEL_W-1:0]        psel;
   logic [63:0]              last_blk   [NUM_SETS];
   logic signed [SCORE_W-1:0] stride_tbl [NUM_SETS];
   logic                     stream_tbl [NUM_SETS];
   logic [LFSR_W-1:0]        lfsr;

   // stimulus-side address streams, one cursor per set
   logic [63:0] stream_at [NUM_SETS];
   bit          stream_dn [NUM_SETS];

   access_type          access_q [$];
   logic [IN_WAY_W-1:0] victim_q [$];

   access_type next_beat;
   access_type taken_beat;
   int      gap_left;
   int      beats_sent;
   int      stall_left;
   int      next_stall;
   int      rsp_count;
   int      errors;
   logic [IN_WAY_W-1:0] want_way;

   function automatic role_type role_of(int s);
      if (s < LEADERS / 3) return ROLE_SRRIP;
      if (s < 2 * LEADERS / 3) return ROLE_BRRIP;
      if (s < LEADERS) return ROLE_LIP;
      return ROLE_FOLLOW;
   endfunction

   function automatic logic [RRPV_W-1:0] brrip_depth();
      logic fb;
      fb = lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5];
      lfsr = {fb, lfsr[LFSR_W-1:1]};
      return (lfsr[DRAW_BITS-1:0] == '0) ? RRPV_NEAR : RRPV_LONG;
   endfunction

   function automatic void move_duel(role_type r);
      if (r == ROLE_SRRIP && psel != DUEL_MAX) psel = psel + 1'b1;
      else if (r == ROLE_BRRIP && psel != '0) psel = psel - 1'b1;
   endfunction

   function automatic void reset_mirror();
      for (int s = 0; s < NUM_SETS; s++) begin
         for (int w = 0; w < NUM_WAYS; w++) rrpv_tbl[s][w] = RRPV_MAX;
         last_blk[s]   = '0;
         stride_tbl[s] = '0;
         stream_tbl[s] = 1'b0;
      end
      psel = DUEL_MID;
      lfsr = LFSR_SEED;
   endfunction

   function automatic void apply_access(access_type a);
      int s;
      int w;
      int sc;
      logic [RRPV_W-1:0] top;
      logic [RRPV_W-1:0] depth;
      logic [63:0] blk;
      logic [63:0] delta;
      role_type role;
      s = int'(a.set_index);
      if (a.kind == KIND_VICTIM) begin
         for (w = 0; w < NUM_WAYS; w++) begin
            if (!a.valid_mask[w]) begin
               victim_q.push_back(IN_WAY_W'(w));
               return;
            end
         end
         top = '0;
         for (w = 0; w < NUM_WAYS; w++)
            if (rrpv_tbl[s][w] > top) top = rrpv_tbl[s][w];
         // age the whole row so the oldest way lands at max
         for (w = 0; w < NUM_WAYS; w++) rrpv_tbl[s][w] = rrpv_tbl[s][w] + (RRPV_MAX - top);
         for (w = 0; w < NUM_WAYS; w++) begin
            if (rrpv_tbl[s][w] == RRPV_MAX) begin
               victim_q.push_back(IN_WAY_W'(w));
               return;
            end
         end
         return;
      end
      w    = int'(a.way_index);
      role = role_of(s);
      blk  = a.phys_addr >> LINE_BITS;
      if (last_blk[s] != '0) begin
         delta = blk - last_blk[s];
         sc = int'(stride_tbl[s]);
         if (delta == 64'd1 || delta == '1) sc = (sc < SCORE_MAX) ? sc + 1 : SCORE_MAX;
         else sc = (sc > SCORE_MIN) ? sc - 1 : SCORE_MIN;
         stride_tbl[s] = sc[SCORE_W-1:0];
         stream_tbl[s] = (sc >= SCORE_STREAM);
      end
      last_blk[s] = blk;
      if (a.is_hit) begin
         rrpv_tbl[s][w] = RRPV_NEAR;
         move_duel(role);
         return;
      end
      if (stream_tbl[s]) begin
         rrpv_tbl[s][w] = RRPV_MAX;
         return;
      end
      case (role)
         ROLE_SRRIP: depth = RRPV_LONG;
         ROLE_BRRIP: depth = brrip_depth();
         ROLE_LIP:   depth = RRPV_MAX;
         default:    depth = (psel >= DUEL_MID) ? RRPV_LONG : brrip_depth();
      endcase
      rrpv_tbl[s][w] = depth;
      move_duel(role);
   endfunction

   function automatic void push_access(logic kind, int s, int w, logic [MASK_W-1:0] mask,
                                       logic [ADDR_W-1:0] addr, logic hit);
      access_type a;
      a.kind       = kind;
      a.set_index  = IN_SET_W'(s);
      a.way_index  = IN_WAY_W'(w);
      a.valid_mask = mask;
      a.phys_addr  = addr;
      a.is_hit     = hit;
      access_q.push_back(a);
   endfunction

   // mostly unit strides, some repeats, some noise and stream breaks
   function automatic logic [63:0] next_addr(int s);
      int r;
      r = $urandom_range(0, 9);
      if (r < 6)
         stream_at[s] = stream_dn[s] ? stream_at[s] - 64 : stream_at[s] + 64;
      else if (r == 8)
         return {$urandom, $urandom};
      else if (r == 9) begin
         stream_at[s] = {$urandom, $urandom} & ~64'h3F;
         stream_dn[s] = 1'($urandom_range(0, 1));
      end
      return stream_at[s] | 64'($urandom_range(0, 63));
   endfunction

   function automatic logic [MASK_W-1:0] draw_mask();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return '1;
      if (r < 85) return ~(16'h1 << $urandom_range(0, 15));
      return MASK_W'($urandom);
   endfunction

   function automatic role_type pick_role(int phase);
      int r;
      r = $urandom_range(0, 99);
      if (phase == 2) return role_type'(r / 25);
      if (r < 70) return (phase == 0) ? ROLE_BRRIP : ROLE_SRRIP;
      if (r < 75) return (phase == 0) ? ROLE_SRRIP : ROLE_BRRIP;
      if (r < 85) return ROLE_LIP;
      return ROLE_FOLLOW;
   endfunction

   function automatic int hot_set(role_type r, bit alt);
      case (r)
         ROLE_SRRIP: return alt ? 17 : 3;
         ROLE_BRRIP: return alt ? 40 : 22;
         ROLE_LIP:   return alt ? 63 : 45;
         default:    return alt ? 2047 : 700;
      endcase
   endfunction

   // one stretch of 40 beats in every 120 runs with no idling
   function automatic int idle_draw(int n);
      if ((n / 40) % 3 == 1) return 0;
      return $urandom_range(0, 10);
   endfunction

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         gap_left     <= 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            taken_beat.kind       = req_if.kind;
            taken_beat.set_index  = req_if.set_index;
            taken_beat.way_index  = req_if.way_index;
            taken_beat.valid_mask = req_if.valid_mask;
            taken_beat.phys_addr  = req_if.phys_addr;
            taken_beat.is_hit     = req_if.is_hit;
            apply_access(taken_beat);
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_left != 0 || access_q.size() == 0) begin
               req_if.valid <= 1'b0;
               if (gap_left != 0) gap_left <= gap_left - 1;
            end else begin
               next_beat = access_q.pop_front();
               req_if.valid      <= 1'b1;
               req_if.kind       <= next_beat.kind;
               req_if.set_index  <= next_beat.set_index;
               req_if.way_index  <= next_beat.way_index;
               req_if.valid_mask <= next_beat.valid_mask;
               req_if.phys_addr  <= next_beat.phys_addr;
               req_if.is_hit     <= next_beat.is_hit;
               gap_left          <= idle_draw(beats_sent);
               beats_sent++;
            end
         end
      end
   end

   // monitor; one long hold-off lets the block back up into its input
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (victim_q.size() == 0) begin
               $display("%0t: victim way %0d with no request pending (expected none)",
                        $time, rsp_if.victim_way);
               errors++;
            end else begin
               want_way = victim_q.pop_front();
               if (rsp_if.victim_way !== want_way) begin
                  $display("%0t: victim way mismatch: expected %0d, actual %0d",
                           $time, want_way, rsp_if.victim_way);
                  errors++;
               end
            end
            next_stall = (rsp_count == HOLD_AT) ? LONG_HOLD : idle_draw(rsp_count);
            rsp_count++;
         end else begin
            next_stall = (stall_left > 0) ? stall_left - 1 : 0;
         end
         stall_left   <= next_stall;
         rsp_if.ready <= (next_stall == 0);
      end
   end

   initial begin
      int i;
      int s;
      int r;
      int phase;
      reset = 1'b1;
      reset_mirror();
      for (s = 0; s < NUM_SETS; s++) begin
         stream_at[s] = {$urandom, $urandom} & ~64'h3F;
         stream_dn[s] = 1'($urandom_range(0, 1));
      end

      // directed: mask extremes, stride walk up and down, block zero, every set role
      push_access(KIND_VICTIM, 0, 9, 16'h0000, '1, 1'b1);
      push_access(KIND_VICTIM, 2047, 0, 16'h7FFF, '0, 1'b0);
      push_access(KIND_VICTIM, 1, 3, 16'hFFFF, 64'h1234, 1'b0);
      push_access(KIND_UPDATE, 3, 0, 16'h0000, 64'h1000, 1'b0);
      push_access(KIND_UPDATE, 3, 15, 16'hFFFF, 64'h1040, 1'b1);
      push_access(KIND_UPDATE, 3, 7, 16'h0000, 64'h1080, 1'b0);
      push_access(KIND_UPDATE, 3, 9, 16'hFFFF, 64'h10C0, 1'b0);
      push_access(KIND_UPDATE, 3, 2, 16'h0000, 64'h1080, 1'b0);
      push_access(KIND_UPDATE, 3, 5, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      push_access(KIND_UPDATE, 3, 6, 16'h0000, 64'h0, 1'b0);
      push_access(KIND_UPDATE, 3, 8, 16'hFFFF, 64'h40, 1'b1);
      push_access(KIND_VICTIM, 3, 0, 16'hFFFF, '0, 1'b0);
      push_access(KIND_UPDATE, 25, 1, 16'h0000, 64'h8000_0000_0000_0000, 1'b0);
      push_access(KIND_UPDATE, 25, 1, 16'hFFFF, 64'h5555_5555_5555_5540, 1'b1);
      push_access(KIND_UPDATE, 50, 3, 16'h0000, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
      push_access(KIND_UPDATE, 1000, 4, 16'h0000, 64'h2000, 1'b0);
      push_access(KIND_UPDATE, 1000, 4, 16'hFFFF, 64'h9000, 1'b1);
      push_access(KIND_VICTIM, 1000, 0, 16'hFFEF, '0, 1'b0);
      push_access(KIND_VICTIM, 1000, 0, 16'hFFFF, '0, 1'b0);
      push_access(KIND_UPDATE, 20, 12, 16'h0000, 64'h3000, 1'b0);
      push_access(KIND_UPDATE, 21, 11, 16'h0000, 64'h3040, 1'b0);
      push_access(KIND_UPDATE, 42, 10, 16'h0000, 64'h3080, 1'b0);
      push_access(KIND_UPDATE, 63, 14, 16'h0000, 64'h30C0, 1'b0);
      push_access(KIND_UPDATE, 64, 13, 16'h0000, 64'h3100, 1'b0);
      push_access(KIND_VICTIM, 2047, 0, 16'hFFFF, '0, 1'b0);

      // random: first pull the duel counter down, then up, then mix
      i = 0;
      while (i < RANDOM_BEATS) begin
         phase = (i < 650) ? 0 : (i < 1300) ? 1 : 2;
         if ($urandom_range(0, 99) < 10) s = $urandom_range(0, NUM_SETS - 1);
         else s = hot_set(pick_role(phase), 1'($urandom_range(0, 1)));
         r = $urandom_range(0, 99);
         if (r < 25) begin
            // miss: victim lookup followed by the fill
            push_access(KIND_VICTIM, s, $urandom_range(0, 15), draw_mask(),
                        {$urandom, $urandom}, 1'($urandom_range(0, 1)));
            push_access(KIND_UPDATE, s, $urandom_range(0, 15), MASK_W'($urandom),
                        next_addr(s), 1'b0);
            i += 2;
         end else if (r < 35) begin
            push_access(KIND_VICTIM, s, $urandom_range(0, 15), draw_mask(),
                        {$urandom, $urandom}, 1'($urandom_range(0, 1)));
            i++;
         end else begin
            push_access(KIND_UPDATE, s, $urandom_range(0, 15), MASK_W'($urandom),
                        next_addr(s), 1'($urandom_range(0, 1)));
            i++;
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (access_q.size() != 0 || req_if.valid) @(posedge clock);
      while (victim_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
